// File: design/bright_spot_bounding_box_assert.svh
// Assertion macros for the bright-spot bounding box block.
// Included by the top level; needs no other file.
`ifndef BRIGHT_SPOT_BOUNDING_BOX_ASSERT_SVH
`define BRIGHT_SPOT_BOUNDING_BOX_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define BSBB_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSBB_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define BSBB_ASSERT_NOW(label, clk, rst_n, cond, prop, msg)
`define BSBB_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

// File: design/bsbb_pkg.sv
// Shared constants and types for the bright-spot bounding box block.
// No dependencies.
`default_nettype none

package bsbb_pkg;

    // Field widths
    localparam int PIXEL_W  = 8;
    localparam int ROW_W    = 7;
    localparam int COL_W    = 8;
    localparam int OFFSET_W = 9;
    localparam int COUNT_W  = 15;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 9;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_BINARY_THRESHOLD = 4'd0;
    localparam t_cfg_index CFG_AUTO_FLOOR       = 4'd1;
    localparam t_cfg_index CFG_CENTRE_REFERENCE = 4'd2;
    localparam t_cfg_index CFG_LOST_OFFSET      = 4'd3;

    // Register reset values
    localparam logic [PIXEL_W-1:0]         RST_BINARY_THRESHOLD = 8'd100;
    localparam logic [PIXEL_W-1:0]         RST_AUTO_FLOOR       = 8'd120;
    localparam logic [COL_W-1:0]           RST_CENTRE_REFERENCE = 8'd80;
    localparam logic signed [OFFSET_W-1:0] RST_LOST_OFFSET      = 9'sd80;

    // Arithmetic constants
    localparam logic [PIXEL_W-1:0] AUTO_MARGIN  = 8'd3;
    localparam logic [COUNT_W-1:0] WHITE_MAX    = 15'd32767;
    localparam int                 DIFF_W       = 12;
    localparam logic signed [DIFF_W-1:0] OFFSET_LIMIT = 12'sd255;

endpackage

`default_nettype wire

// File: design/bright_spot_bounding_box.sv
// Bright-spot bounding box: per-frame white-pixel box, centre and steering offset.
// Depends on bsbb_pkg and bright_spot_bounding_box_assert.svh.
//
// Usage:
//   Pixels enter in raster order on i_valid / o_stall with i_pixel_value and
//   i_frame_end; an item is taken at an edge where i_valid is high and o_stall
//   low. One item is taken per cycle. Only the item flagged i_frame_end makes a
//   result; all others just update the frame accumulators.
//   The result leaves on o_valid / i_stall after the frame-end item is taken: it
//   is first folded into a frame snapshot, then the snapshot is turned into box,
//   centre, offset and threshold in the output register.
//   Throughput is one pixel per clock, set by the accumulator register stage.
//   While the receiver stalls, the result holds; a second finished frame can
//   wait in the snapshot register, and o_stall rises only when both are full.
//   Configuration writes go through i_cfg_valid / o_cfg_ready (always ready),
//   indexed by i_cfg_index; indexes beyond the register list are ignored.
//   Write configuration only while no frame result is pending.
//   Synchronous active-low reset restores register defaults, clears the frame
//   accumulators and empties both pipeline stages.
`default_nettype none

`include "bright_spot_bounding_box_assert.svh"

module bright_spot_bounding_box #(
    parameter int IMG_HEIGHT = 120,
    parameter int IMG_WIDTH  = 160
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // pixel input
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [bsbb_pkg::PIXEL_W-1:0]          i_pixel_value,
    input  wire logic                                  i_frame_end,
    // configuration writes
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire bsbb_pkg::t_cfg_index                  i_cfg_index,
    input  wire logic [bsbb_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // frame result
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [bsbb_pkg::ROW_W-1:0]                 o_box_top,
    output logic [bsbb_pkg::ROW_W-1:0]                 o_box_bottom,
    output logic [bsbb_pkg::COL_W-1:0]                 o_box_left,
    output logic [bsbb_pkg::COL_W-1:0]                 o_box_right,
    output logic [bsbb_pkg::ROW_W-1:0]                 o_centre_row,
    output logic [bsbb_pkg::COL_W-1:0]                 o_centre_column,
    output logic signed [bsbb_pkg::OFFSET_W-1:0]       o_steer_offset,
    output logic                                       o_light_found,
    output logic [bsbb_pkg::COUNT_W-1:0]               o_white_count,
    output logic [bsbb_pkg::PIXEL_W-1:0]               o_auto_threshold
);

    localparam int RW = (IMG_HEIGHT > 2) ? $clog2(IMG_HEIGHT) : 1;
    localparam int CW = (IMG_WIDTH > 2) ? $clog2(IMG_WIDTH) : 1;
    localparam logic [RW-1:0] LAST_ROW = RW'(IMG_HEIGHT - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(IMG_WIDTH - 1);
    localparam int WIDE_W = 16;

    // Configuration registers
    logic [bsbb_pkg::PIXEL_W-1:0]          r_binary_threshold;
    logic [bsbb_pkg::PIXEL_W-1:0]          r_auto_floor;
    logic [bsbb_pkg::COL_W-1:0]            r_centre_ref;
    logic signed [bsbb_pkg::OFFSET_W-1:0]  r_lost_offset;

    // Frame accumulators
    logic [RW-1:0]                r_row, n_row;
    logic [CW-1:0]                r_col, n_col;
    logic [bsbb_pkg::PIXEL_W-1:0] r_bright, n_bright;
    logic [bsbb_pkg::COUNT_W-1:0] r_total, n_total;
    logic [RW-1:0]                r_min_row, n_min_row, r_max_row, n_max_row;
    logic [CW-1:0]                r_min_col, n_min_col, r_max_col, n_max_col;
    logic                         r_any_white, n_any_white;

    // Frame snapshot
    logic                         r_snap_valid;
    logic [bsbb_pkg::PIXEL_W-1:0] r_snap_bright;
    logic [bsbb_pkg::COUNT_W-1:0] r_snap_total;
    logic [RW-1:0]                r_snap_min_row, r_snap_max_row;
    logic [CW-1:0]                r_snap_min_col, r_snap_max_col;
    logic                         r_snap_any;

    // Output register
    logic r_out_valid;

    logic in_take, snap_load, out_free, snap_adv, white;

    // Handshakes
    assign out_free    = !r_out_valid || !i_stall;
    assign snap_adv    = r_snap_valid && out_free;
    assign o_stall     = r_snap_valid && r_out_valid && i_stall;
    assign in_take     = i_valid && !o_stall;
    assign snap_load   = in_take && i_frame_end;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;

    // Fold the pixel into the accumulators
    always_comb begin
        white       = i_pixel_value >= r_binary_threshold;
        n_bright    = (i_pixel_value >= r_bright) ? i_pixel_value : r_bright;
        n_total     = (white && r_total != bsbb_pkg::WHITE_MAX) ?
                      r_total + 1'b1 : r_total;
        n_min_row   = (white && (!r_any_white || r_row < r_min_row)) ? r_row : r_min_row;
        n_max_row   = (white && (!r_any_white || r_row > r_max_row)) ? r_row : r_max_row;
        n_min_col   = (white && (!r_any_white || r_col < r_min_col)) ? r_col : r_min_col;
        n_max_col   = (white && (!r_any_white || r_col > r_max_col)) ? r_col : r_max_col;
        n_any_white = r_any_white || white;
        // advance raster position; the row sticks at the last row
        if (r_col >= LAST_COL) begin
            n_col = '0;
            n_row = (r_row < LAST_ROW) ? r_row + 1'b1 : r_row;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binary_threshold <= bsbb_pkg::RST_BINARY_THRESHOLD;
            r_auto_floor       <= bsbb_pkg::RST_AUTO_FLOOR;
            r_centre_ref       <= bsbb_pkg::RST_CENTRE_REFERENCE;
            r_lost_offset      <= bsbb_pkg::RST_LOST_OFFSET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bsbb_pkg::CFG_BINARY_THRESHOLD: r_binary_threshold <= i_cfg_data[7:0];
                bsbb_pkg::CFG_AUTO_FLOOR:       r_auto_floor       <= i_cfg_data[7:0];
                bsbb_pkg::CFG_CENTRE_REFERENCE: r_centre_ref       <= i_cfg_data[7:0];
                bsbb_pkg::CFG_LOST_OFFSET:      r_lost_offset      <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Accumulators: update per item, clear after the frame-end item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || snap_load) begin
            r_row       <= '0;
            r_col       <= '0;
            r_bright    <= '0;
            r_total     <= '0;
            r_min_row   <= LAST_ROW;
            r_max_row   <= '0;
            r_min_col   <= LAST_COL;
            r_max_col   <= '0;
            r_any_white <= 1'b0;
        end else if (in_take) begin
            r_row       <= n_row;
            r_col       <= n_col;
            r_bright    <= n_bright;
            r_total     <= n_total;
            r_min_row   <= n_min_row;
            r_max_row   <= n_max_row;
            r_min_col   <= n_min_col;
            r_max_col   <= n_max_col;
            r_any_white <= n_any_white;
        end
    end

    // Snapshot control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (snap_load) begin
            r_snap_valid <= 1'b1;
        end else if (snap_adv) begin
            r_snap_valid <= 1'b0;
        end
    end

    // Snapshot payload: final frame values including the frame-end pixel
    always_ff @(posedge i_clk) begin
        if (snap_load) begin
            r_snap_bright  <= n_bright;
            r_snap_total   <= n_total;
            r_snap_min_row <= n_min_row;
            r_snap_max_row <= n_max_row;
            r_snap_min_col <= n_min_col;
            r_snap_max_col <= n_max_col;
            r_snap_any     <= n_any_white;
        end
    end

    // Result arithmetic from the snapshot
    logic [RW:0]                  top_w, bottom_w, crow_sum;
    logic [CW:0]                  left_w, right_w, ccol_sum;
    logic [RW-1:0]                top, bottom, crow;
    logic [CW-1:0]                left, right, ccol;
    logic signed [bsbb_pkg::DIFF_W-1:0] diff, diff_c;
    logic [bsbb_pkg::PIXEL_W-1:0] autoth_raw, autoth;
    logic [WIDE_W-1:0]            top_x, bottom_x, left_x, right_x, crow_x, ccol_x;
    logic signed [bsbb_pkg::OFFSET_W-1:0] offset;

    always_comb begin
        top_w    = (r_snap_min_row != '0) ? {1'b0, r_snap_min_row} - 1'b1 : '0;
        bottom_w = {1'b0, r_snap_max_row} + 1'b1;
        if (bottom_w >= {1'b0, LAST_ROW}) begin
            bottom_w = {1'b0, LAST_ROW};
        end
        left_w   = (r_snap_min_col != '0) ? {1'b0, r_snap_min_col} - 1'b1 : '0;
        right_w  = {1'b0, r_snap_max_col} + 1'b1;
        if (right_w >= {1'b0, LAST_COL}) begin
            right_w = {1'b0, LAST_COL};
        end
        crow_sum = top_w + bottom_w;
        ccol_sum = left_w + right_w;

        // nothing white: report the empty box
        if (r_snap_any) begin
            top    = top_w[RW-1:0];
            bottom = bottom_w[RW-1:0];
            left   = left_w[CW-1:0];
            right  = right_w[CW-1:0];
            crow   = crow_sum[RW:1];
            ccol   = ccol_sum[CW:1];
        end else begin
            top    = LAST_ROW;
            bottom = '0;
            left   = LAST_COL;
            right  = '0;
            crow   = '0;
            ccol   = '0;
        end

        // steering offset, clamped to -255..255 within the 9-bit range
        diff   = signed'(bsbb_pkg::DIFF_W'(ccol)) - signed'(bsbb_pkg::DIFF_W'(r_centre_ref));
        diff_c = diff;
        if (diff > bsbb_pkg::OFFSET_LIMIT) begin
            diff_c = bsbb_pkg::OFFSET_LIMIT;
        end else if (diff < -bsbb_pkg::OFFSET_LIMIT) begin
            diff_c = -bsbb_pkg::OFFSET_LIMIT;
        end
        offset = r_snap_any ? diff_c[bsbb_pkg::OFFSET_W-1:0] : r_lost_offset;

        // brightest minus margin, floored
        autoth_raw = (r_snap_bright >= bsbb_pkg::AUTO_MARGIN) ?
                     r_snap_bright - bsbb_pkg::AUTO_MARGIN : '0;
        autoth     = (autoth_raw <= r_auto_floor) ? r_auto_floor : autoth_raw;

        // widen before masking to the field widths
        top_x    = WIDE_W'(top);
        bottom_x = WIDE_W'(bottom);
        left_x   = WIDE_W'(left);
        right_x  = WIDE_W'(right);
        crow_x   = WIDE_W'(crow);
        ccol_x   = WIDE_W'(ccol);
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (snap_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (snap_adv) begin
            o_box_top        <= top_x[bsbb_pkg::ROW_W-1:0];
            o_box_bottom     <= bottom_x[bsbb_pkg::ROW_W-1:0];
            o_box_left       <= left_x[bsbb_pkg::COL_W-1:0];
            o_box_right      <= right_x[bsbb_pkg::COL_W-1:0];
            o_centre_row     <= crow_x[bsbb_pkg::ROW_W-1:0];
            o_centre_column  <= ccol_x[bsbb_pkg::COL_W-1:0];
            o_steer_offset   <= offset;
            o_light_found    <= r_snap_any;
            o_white_count    <= r_snap_total;
            o_auto_threshold <= autoth;
        end
    end

    // Checks
    `BSBB_ASSERT_NEXT(a_frame_end_snaps, i_clk, i_rst_n, snap_load, r_snap_valid, "frame end not captured")
    `BSBB_ASSERT_NOW(a_empty_box_idle, i_clk, i_rst_n, !r_any_white, (r_min_row == LAST_ROW) && (r_max_row == '0) && (r_min_col == LAST_COL) && (r_max_col == '0), "box moved without white pixel")
    `BSBB_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, r_out_valid && i_stall, r_out_valid, "stalled result dropped")
    `BSBB_ASSERT_NOW(a_col_in_range, i_clk, i_rst_n, 1'b1, r_col <= LAST_COL, "column past row end")

endmodule

`default_nettype wire

// File: verif/tb_bright_spot_bounding_box.sv
// Self-checking testbench for the bright-spot bounding box: drives pixel frames and
// register writes with random gaps and stalls, and checks every frame report.
// Depends on bsbb_pkg and the bright_spot_bounding_box top level.
`timescale 1ns / 1ps

module tb_bright_spot_bounding_box;

    localparam int IMG_H         = 120;
    localparam int IMG_W         = 160;
    localparam int PIPE_SLACK    = 4;     // cycles to let in-flight pixels settle
    localparam int DRAIN_LIMIT   = 5000;  // cycles to wait for pending reports
    localparam int LONG_HOLD     = 300;   // receiver hold-off under pressure
    localparam int BURST_FRAMES  = 24;
    localparam int RANDOM_ITEMS  = 400;
    localparam int MIN_REPORTS   = 55;

    localparam bsbb_pkg::t_cfg_index CFG_UNUSED_LOW = 4'd4;
    localparam bsbb_pkg::t_cfg_index CFG_UNUSED_TOP = 4'd15;

    typedef struct packed {
        logic [bsbb_pkg::ROW_W-1:0]    box_top;
        logic [bsbb_pkg::ROW_W-1:0]    box_bottom;
        logic [bsbb_pkg::COL_W-1:0]    box_left;
        logic [bsbb_pkg::COL_W-1:0]    box_right;
        logic [bsbb_pkg::ROW_W-1:0]    centre_row;
        logic [bsbb_pkg::COL_W-1:0]    centre_column;
        logic [bsbb_pkg::OFFSET_W-1:0] steer_offset;
        logic                          light_found;
        logic [bsbb_pkg::COUNT_W-1:0]  white_count;
        logic [bsbb_pkg::PIXEL_W-1:0]  auto_threshold;
    } t_box_report;

    typedef struct packed {
        bsbb_pkg::t_cfg_index            idx;
        logic [bsbb_pkg::CFG_DATA_W-1:0] data;
    } t_reg_write;

    typedef enum logic {ROW_PIXELS, ROW_WRITE} t_row_kind;

    // One row of the directed plan: a run of equal pixels or a register write
    typedef struct packed {
        t_row_kind                       kind;
        bsbb_pkg::t_cfg_index            reg_index;
        logic [bsbb_pkg::CFG_DATA_W-1:0] reg_data;
        int                              run_len;
        logic [bsbb_pkg::PIXEL_W-1:0]    level;
        logic                            ends_frame;
        logic                            typed;
        t_box_report                     want;
    } t_plan_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic [bsbb_pkg::PIXEL_W-1:0]      i_pixel_value = '0;
    logic                              i_frame_end = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    bsbb_pkg::t_cfg_index              i_cfg_index = '0;
    logic [bsbb_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic [bsbb_pkg::ROW_W-1:0]        o_box_top;
    logic [bsbb_pkg::ROW_W-1:0]        o_box_bottom;
    logic [bsbb_pkg::COL_W-1:0]        o_box_left;
    logic [bsbb_pkg::COL_W-1:0]        o_box_right;
    logic [bsbb_pkg::ROW_W-1:0]        o_centre_row;
    logic [bsbb_pkg::COL_W-1:0]        o_centre_column;
    logic signed [bsbb_pkg::OFFSET_W-1:0] o_steer_offset;
    logic                              o_light_found;
    logic [bsbb_pkg::COUNT_W-1:0]      o_white_count;
    logic [bsbb_pkg::PIXEL_W-1:0]      o_auto_threshold;

    bright_spot_bounding_box #(
        .IMG_HEIGHT(IMG_H),
        .IMG_WIDTH (IMG_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel_value   (i_pixel_value),
        .i_frame_end     (i_frame_end),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_box_top       (o_box_top),
        .o_box_bottom    (o_box_bottom),
        .o_box_left      (o_box_left),
        .o_box_right     (o_box_right),
        .o_centre_row    (o_centre_row),
        .o_centre_column (o_centre_column),
        .o_steer_offset  (o_steer_offset),
        .o_light_found   (o_light_found),
        .o_white_count   (o_white_count),
        .o_auto_threshold(o_auto_threshold)
    );

    // Register copies kept by the testbench
    logic [bsbb_pkg::PIXEL_W-1:0]  th_white   = bsbb_pkg::RST_BINARY_THRESHOLD;
    logic [bsbb_pkg::PIXEL_W-1:0]  th_floor   = bsbb_pkg::RST_AUTO_FLOOR;
    logic [bsbb_pkg::COL_W-1:0]    centre_ref = bsbb_pkg::RST_CENTRE_REFERENCE;
    logic [bsbb_pkg::OFFSET_W-1:0] lost_code  = bsbb_pkg::RST_LOST_OFFSET;

    // Frame accumulators kept by the testbench
    int                           row_pos, col_pos, row_lo, row_hi, col_lo, col_hi, lit_count;
    logic [bsbb_pkg::PIXEL_W-1:0] peak;
    bit                           seen_white;

    t_box_report pending_reports[$];
    t_reg_write  cfg_batch[$];
    bit          failed = 1'b0;
    int          reports_seen = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int          holds_asked = 0;
    int          holds_granted = 0;
    int          stall_left = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Bound the whole run
    initial begin : watchdog
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_box_report frame_report(input int tp, input int bt, input int lf,
                                                 input int rt, input int cr, input int cc,
                                                 input int so, input int fd, input int wc,
                                                 input int at);
        t_box_report r;
        r.box_top        = bsbb_pkg::ROW_W'(tp);
        r.box_bottom     = bsbb_pkg::ROW_W'(bt);
        r.box_left       = bsbb_pkg::COL_W'(lf);
        r.box_right      = bsbb_pkg::COL_W'(rt);
        r.centre_row     = bsbb_pkg::ROW_W'(cr);
        r.centre_column  = bsbb_pkg::COL_W'(cc);
        r.steer_offset   = bsbb_pkg::OFFSET_W'(so);
        r.light_found    = fd[0];
        r.white_count    = bsbb_pkg::COUNT_W'(wc);
        r.auto_threshold = bsbb_pkg::PIXEL_W'(at);
        return r;
    endfunction

    function automatic t_plan_row pixels(input int len,
                                         input logic [bsbb_pkg::PIXEL_W-1:0] level,
                                         input logic ends);
        t_plan_row p;
        p            = '0;
        p.kind       = ROW_PIXELS;
        p.run_len    = len;
        p.level      = level;
        p.ends_frame = ends;
        return p;
    endfunction

    function automatic t_plan_row pixels_then(input int len,
                                              input logic [bsbb_pkg::PIXEL_W-1:0] level,
                                              input t_box_report want);
        t_plan_row p;
        p       = pixels(len, level, 1'b1);
        p.typed = 1'b1;
        p.want  = want;
        return p;
    endfunction

    function automatic t_plan_row reg_write(input bsbb_pkg::t_cfg_index idx,
                                            input logic [bsbb_pkg::CFG_DATA_W-1:0] data);
        t_plan_row p;
        p           = '0;
        p.kind      = ROW_WRITE;
        p.reg_index = idx;
        p.reg_data  = data;
        return p;
    endfunction

    task automatic restart_frame();
        row_pos    = 0;
        col_pos    = 0;
        peak       = '0;
        lit_count  = 0;
        row_lo     = IMG_H - 1;
        row_hi     = 0;
        col_lo     = IMG_W - 1;
        col_hi     = 0;
        seen_white = 1'b0;
    endtask

    // Fold one accepted pixel into the frame; on frame end queue the report
    task automatic take_pixel(input logic [bsbb_pkg::PIXEL_W-1:0] level, input logic ends);
        t_box_report r;
        int auto_lvl, top, bottom, left_c, right_c, crow, ccol, steer;
        if (level >= peak) peak = level;
        if (level >= th_white) begin
            if (lit_count < bsbb_pkg::WHITE_MAX) lit_count++;
            if (!seen_white || row_pos < row_lo) row_lo = row_pos;
            if (!seen_white || row_pos > row_hi) row_hi = row_pos;
            if (!seen_white || col_pos < col_lo) col_lo = col_pos;
            if (!seen_white || col_pos > col_hi) col_hi = col_pos;
            seen_white = 1'b1;
        end
        if (!ends) begin
            // advance raster position; the row sticks at the last one
            if (col_pos >= IMG_W - 1) begin
                col_pos = 0;
                if (row_pos < IMG_H - 1) row_pos++;
            end else begin
                col_pos++;
            end
            return;
        end
        auto_lvl = (peak >= bsbb_pkg::AUTO_MARGIN) ?
                   int'(peak) - int'(bsbb_pkg::AUTO_MARGIN) : 0;
        if (auto_lvl <= int'(th_floor)) auto_lvl = th_floor;
        if (seen_white) begin
            top     = (row_lo > 0) ? row_lo - 1 : 0;
            bottom  = (row_hi + 1 < IMG_H - 1) ? row_hi + 1 : IMG_H - 1;
            left_c  = (col_lo > 0) ? col_lo - 1 : 0;
            right_c = (col_hi + 1 < IMG_W - 1) ? col_hi + 1 : IMG_W - 1;
            crow    = (top + bottom) / 2;
            ccol    = (left_c + right_c) / 2;
            steer   = ccol - int'(centre_ref);
            if (steer > 255) steer = 255;
            if (steer < -255) steer = -255;
            r = frame_report(top, bottom, left_c, right_c, crow, ccol, steer, 1,
                             lit_count, auto_lvl);
        end else begin
            r = frame_report(IMG_H - 1, 0, IMG_W - 1, 0, 0, 0, 0, 0, lit_count, auto_lvl);
            r.steer_offset = lost_code;
        end
        pending_reports.push_back(r);
        restart_frame();
    endtask

    // Offer one pixel and hold it until taken
    task automatic send_pixel(input logic [bsbb_pkg::PIXEL_W-1:0] level, input logic ends);
        i_valid       <= 1'b1;
        i_pixel_value <= level;
        i_frame_end   <= ends;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        take_pixel(level, ends);
    endtask

    task automatic idle_tx();
        int gap;
        gap = pick_gap(tx_idle);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid, wait for every pending report, then let the pipeline go quiet
    task automatic settle_pipeline();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_reports.size() != 0) begin
            $error("%0d frame reports never arrived", pending_reports.size());
            failed = 1'b1;
            pending_reports.delete();
        end
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    // Write the queued registers back to back
    task automatic program_registers();
        t_reg_write w;
        while (cfg_batch.size() != 0) begin
            w = cfg_batch.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= w.idx;
            i_cfg_data  <= w.data;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (w.idx)
                bsbb_pkg::CFG_BINARY_THRESHOLD: th_white   = w.data[bsbb_pkg::PIXEL_W-1:0];
                bsbb_pkg::CFG_AUTO_FLOOR:       th_floor   = w.data[bsbb_pkg::PIXEL_W-1:0];
                bsbb_pkg::CFG_CENTRE_REFERENCE: centre_ref = w.data[bsbb_pkg::COL_W-1:0];
                bsbb_pkg::CFG_LOST_OFFSET:      lost_code  = w.data[bsbb_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic signed [16:0] want,
                               input logic signed [16:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endtask

    task automatic check_report();
        t_box_report want;
        reports_seen++;
        if (pending_reports.size() == 0) begin
            $error("frame report arrived with none pending");
            failed = 1'b1;
            return;
        end
        want = pending_reports.pop_front();
        check_field("box_top",        want.box_top,        o_box_top);
        check_field("box_bottom",     want.box_bottom,     o_box_bottom);
        check_field("box_left",       want.box_left,       o_box_left);
        check_field("box_right",      want.box_right,      o_box_right);
        check_field("centre_row",     want.centre_row,     o_centre_row);
        check_field("centre_column",  want.centre_column,  o_centre_column);
        check_field("steer_offset",   $signed(want.steer_offset), o_steer_offset);
        check_field("light_found",    want.light_found,    o_light_found);
        check_field("white_count",    want.white_count,    o_white_count);
        check_field("auto_threshold", want.auto_threshold, o_auto_threshold);
    endtask

    // Take reports and stall at random; a requested hold blocks the output for long
    always @(posedge i_clk) begin : report_sink
        if (i_rst_n && o_valid && !i_stall) check_report();
        if (holds_granted != holds_asked) begin
            holds_granted = holds_asked;
            stall_left    = LONG_HOLD;
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            stall_left = pick_gap(rx_idle);
        end
    end

    initial begin : stimulus
        t_plan_row                    plan[$];
        t_reg_write                   w;
        int                           n, frame_no, frame_len, pick, near_lvl, random_items;
        int                           n_writes;
        logic [bsbb_pkg::PIXEL_W-1:0] level;
        bit                           quiet;

        restart_frame();

        // Directed frames: empty, corner, right-edge clamp, register extremes
        plan.push_back(pixels_then(1, 8'd0,
                       frame_report(119, 0, 159, 0, 0, 0, 80, 0, 0, 120)));
        plan.push_back(pixels_then(1, 8'd255,
                       frame_report(0, 1, 0, 1, 0, 0, -80, 1, 1, 252)));
        plan.push_back(pixels(IMG_W - 1, 8'd0, 1'b0));
        plan.push_back(pixels_then(1, 8'd255,
                       frame_report(0, 1, 158, 159, 0, 158, 78, 1, 1, 252)));
        plan.push_back(pixels_then(1, 8'd99,
                       frame_report(119, 0, 159, 0, 0, 0, 80, 0, 0, 120)));
        plan.push_back(pixels(37, 8'd0, 1'b0));
        plan.push_back(pixels(3, 8'd180, 1'b0));
        plan.push_back(pixels(20, 8'd50, 1'b0));
        plan.push_back(pixels(1, 8'd10, 1'b1));
        plan.push_back(reg_write(bsbb_pkg::CFG_BINARY_THRESHOLD, 9'h000));
        plan.push_back(reg_write(bsbb_pkg::CFG_AUTO_FLOOR, 9'h000));
        plan.push_back(reg_write(bsbb_pkg::CFG_CENTRE_REFERENCE, 9'h000));
        plan.push_back(reg_write(bsbb_pkg::CFG_LOST_OFFSET, 9'h101));
        plan.push_back(reg_write(CFG_UNUSED_LOW, 9'h1FF));
        plan.push_back(reg_write(CFG_UNUSED_TOP, 9'h1FF));
        plan.push_back(pixels_then(3, 8'd2,
                       frame_report(0, 1, 0, 3, 0, 1, 1, 1, 3, 0)));
        plan.push_back(reg_write(bsbb_pkg::CFG_BINARY_THRESHOLD, 9'h0FF));
        plan.push_back(reg_write(bsbb_pkg::CFG_AUTO_FLOOR, 9'h0FF));
        plan.push_back(reg_write(bsbb_pkg::CFG_CENTRE_REFERENCE, 9'h0FF));
        plan.push_back(reg_write(bsbb_pkg::CFG_LOST_OFFSET, 9'h0FF));
        plan.push_back(pixels_then(1, 8'd254,
                       frame_report(119, 0, 159, 0, 0, 0, 255, 0, 0, 255)));
        plan.push_back(pixels(5, 8'd0, 1'b0));
        plan.push_back(pixels_then(1, 8'd255,
                       frame_report(0, 1, 4, 6, 0, 5, -250, 1, 1, 255)));
        plan.push_back(reg_write(bsbb_pkg::CFG_BINARY_THRESHOLD, 9'h1FF));
        plan.push_back(reg_write(bsbb_pkg::CFG_LOST_OFFSET, 9'h101));
        plan.push_back(pixels_then(1, 8'd17,
                       frame_report(119, 0, 159, 0, 0, 0, -255, 0, 0, 255)));
        plan.push_back(reg_write(bsbb_pkg::CFG_LOST_OFFSET, 9'h1FF));
        plan.push_back(reg_write(bsbb_pkg::CFG_BINARY_THRESHOLD, 9'h080));
        plan.push_back(reg_write(bsbb_pkg::CFG_AUTO_FLOOR, 9'h1AA));
        plan.push_back(pixels_then(1, 8'd127,
                       frame_report(119, 0, 159, 0, 0, 0, -1, 0, 0, 170)));
        plan.push_back(pixels(30, 8'd90, 1'b0));
        plan.push_back(pixels(20, 8'd130, 1'b0));
        plan.push_back(pixels(1, 8'd0, 1'b1));

        // Hold reset, then release
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the plan; long runs go without idling
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                w.idx  = plan[i].reg_index;
                w.data = plan[i].reg_data;
                cfg_batch.push_back(w);
            end else begin
                if (cfg_batch.size() != 0) begin
                    settle_pipeline();
                    program_registers();
                end
                tx_idle = (plan[i].run_len <= 64);
                for (n = 0; n < plan[i].run_len; n++) begin
                    send_pixel(plan[i].level, plan[i].ends_frame && n == plan[i].run_len - 1);
                    if (plan[i].typed && n == plan[i].run_len - 1)
                        pending_reports[pending_reports.size() - 1] = plan[i].want;
                    idle_tx();
                end
            end
        end

        // Pressure: hold the output while single-pixel frames keep coming
        tx_idle = 1'b1;
        settle_pipeline();
        holds_asked <= holds_asked + 1;
        for (n = 0; n < BURST_FRAMES; n++) begin
            send_pixel(bsbb_pkg::PIXEL_W'($urandom_range(0, 255)), 1'b1);
            idle_tx();
        end
        settle_pipeline();

        // Random frames, mostly short, with register changes between some of them
        frame_no     = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS || reports_seen < MIN_REPORTS) begin
            if (frame_no % 8 == 7) begin
                settle_pipeline();
                n_writes = $urandom_range(2, 5);
                repeat (n_writes) begin
                    if ($urandom_range(0, 9) < 8)
                        w.idx = bsbb_pkg::t_cfg_index'(
                                    $urandom_range(bsbb_pkg::CFG_BINARY_THRESHOLD,
                                                   bsbb_pkg::CFG_LOST_OFFSET));
                    else
                        w.idx = bsbb_pkg::t_cfg_index'(
                                    $urandom_range(CFG_UNUSED_LOW, CFG_UNUSED_TOP));
                    w.data = bsbb_pkg::CFG_DATA_W'($urandom);
                    cfg_batch.push_back(w);
                end
                program_registers();
            end
            quiet   = (frame_no >= 10 && frame_no < 18);
            tx_idle = !quiet;
            rx_idle <= !quiet;
            pick = $urandom_range(0, 99);
            if (pick < 95)      frame_len = $urandom_range(1, 16);
            else if (pick < 99) frame_len = $urandom_range(150, 340);
            else                frame_len = $urandom_range(400, 700);
            for (n = 0; n < frame_len; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    level = bsbb_pkg::PIXEL_W'($urandom_range(0, 40));
                end else if (pick < 75) begin
                    // straddle the white threshold
                    near_lvl = int'(th_white) + int'($urandom_range(0, 4)) - 2;
                    if (near_lvl < 0) near_lvl = 0;
                    if (near_lvl > 255) near_lvl = 255;
                    level = bsbb_pkg::PIXEL_W'(near_lvl);
                end else if (pick < 90) begin
                    level = bsbb_pkg::PIXEL_W'($urandom_range(200, 255));
                end else begin
                    level = bsbb_pkg::PIXEL_W'($urandom_range(0, 255));
                end
                send_pixel(level, n == frame_len - 1);
                idle_tx();
                random_items++;
            end
            frame_no++;
        end

        settle_pipeline();
        if (failed)
            $display("RESULT: ERROR");
        else
            $display("RESULT: OK");
        $finish;
    end

endmodule
